[hdl/psu_pkg.sv]
// Shared types, constants and the Paeth predictor for the scanline unfilter.
package psu_pkg;

  localparam int MAX_ROW_BYTES_DEF   = 16384;
  localparam int MAX_PIXEL_BYTES_DEF = 8;
  localparam int QUEUE_DEPTH         = 4;
  localparam int ROW_BYTES_W         = 15;
  localparam int PIXEL_BYTES_W       = 4;
  localparam int CFG_INDEX_W         = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_ROW_BYTES   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_BYTES = 2'd1;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  localparam logic [7:0] FILT_LAST = 8'd4;

  typedef struct packed {
    logic  err;
    filt_t filt;
    logic  first;
    logic  use_a;
    logic  row_end;
    logic  clr;
  } ctl_t;

  function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c);
    logic signed [9:0] sa, sb, sc, p, da, db, dc;
    logic [7:0] pick;
    sa = $signed({2'b00, a});
    sb = $signed({2'b00, b});
    sc = $signed({2'b00, c});
    p  = sa + sb - sc;
    da = p - sa;
    db = p - sb;
    dc = p - sc;
    if (da < 0) da = -da;
    if (db < 0) db = -db;
    if (dc < 0) dc = -dc;
    if (da <= db && da <= dc) pick = a;
    else if (db <= dc) pick = b;
    else pick = c;
    return pick;
  endfunction

endpackage

[hdl/psu_front.sv]
// Front end: config registers, scanline tracking and classification of input bytes.
module psu_front import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int CW   = $clog2(MAX_ROW_BYTES),
  localparam int SW   = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1,
  localparam int RW   = $clog2(MAX_ROW_BYTES + 1),
  localparam int CMPW = (RW > ROW_BYTES_W) ? RW : ROW_BYTES_W
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_BYTES_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   image_start,
  input  logic                   q_full,
  output logic                   push,
  output ctl_t                   e_ctl,
  output logic [CW-1:0]          e_col,
  output logic [SW-1:0]          e_slot,
  output logic [7:0]             e_byte
);

  logic [ROW_BYTES_W-1:0]   row_bytes;
  logic [PIXEL_BYTES_W-1:0] pixel_bytes;

  logic [CW-1:0] column, column_e, column_next;
  logic [SW-1:0] res [MAX_PIXEL_BYTES];
  logic [SW-1:0] res_e [MAX_PIXEL_BYTES];
  logic [SW-1:0] res_next [MAX_PIXEL_BYTES];
  filt_t filter_kind, filter_e, filter_next;
  logic awaiting, awaiting_e, awaiting_next;
  logic first_row, first_e, first_next;
  logic halted, halted_e, halted_next;
  logic pend_clr, pend_e, pend_next;

  logic accept;
  logic [CMPW-1:0] rb_ext, rb_eff, col_inc;
  logic [PIXEL_BYTES_W-1:0] pb_eff;
  logic [SW-1:0] pb_idx;
  logic last;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign e_byte    = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_bytes   <= ROW_BYTES_W'(1);
      pixel_bytes <= PIXEL_BYTES_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ROW_BYTES:   row_bytes   <= cfg_data;
        CFG_PIXEL_BYTES: pixel_bytes <= cfg_data[PIXEL_BYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    rb_ext = CMPW'(row_bytes);
    if (rb_ext == '0) rb_eff = CMPW'(1);
    else if (rb_ext > CMPW'(MAX_ROW_BYTES)) rb_eff = CMPW'(MAX_ROW_BYTES);
    else rb_eff = rb_ext;
    if (pixel_bytes == '0) pb_eff = PIXEL_BYTES_W'(1);
    else if (pixel_bytes > PIXEL_BYTES_W'(MAX_PIXEL_BYTES))
      pb_eff = PIXEL_BYTES_W'(MAX_PIXEL_BYTES);
    else pb_eff = pixel_bytes;
    pb_idx = SW'(pb_eff - PIXEL_BYTES_W'(1));
  end

  always_comb begin
    halted_e   = image_start ? 1'b0 : halted;
    awaiting_e = image_start ? 1'b1 : awaiting;
    first_e    = image_start ? 1'b1 : first_row;
    column_e   = image_start ? '0 : column;
    filter_e   = image_start ? FILT_NONE : filter_kind;
    pend_e     = image_start | pend_clr;
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) res_e[i] = image_start ? '0 : res[i];
  end

  always_comb begin
    col_inc       = CMPW'(column_e) + CMPW'(1);
    last          = col_inc >= rb_eff;
    column_next   = column_e;
    filter_next   = filter_e;
    awaiting_next = awaiting_e;
    first_next    = first_e;
    halted_next   = halted_e;
    pend_next     = pend_e;
    for (int i = 0; i < MAX_PIXEL_BYTES; i++) res_next[i] = res_e[i];
    push          = 1'b0;
    e_ctl         = '0;
    e_col         = column_e;
    e_slot        = res_e[pb_idx];
    if (!halted_e) begin
      if (awaiting_e) begin
        if (in_byte > FILT_LAST) begin
          halted_next = 1'b1;
          push        = accept;
          e_ctl.err   = 1'b1;
        end else begin
          filter_next   = filt_t'(in_byte[2:0]);
          awaiting_next = 1'b0;
          column_next   = '0;
          for (int i = 0; i < MAX_PIXEL_BYTES; i++) res_next[i] = '0;
        end
      end else begin
        push          = accept;
        e_ctl.filt    = filter_e;
        e_ctl.first   = first_e;
        e_ctl.use_a   = CMPW'(column_e) >= CMPW'(pb_eff);
        e_ctl.row_end = last;
        e_ctl.clr     = pend_e;
        pend_next     = 1'b0;
        if (last) begin
          column_next   = '0;
          awaiting_next = 1'b1;
          first_next    = 1'b0;
          for (int i = 0; i < MAX_PIXEL_BYTES; i++) res_next[i] = '0;
        end else begin
          column_next = col_inc[CW-1:0];
          for (int i = 0; i < MAX_PIXEL_BYTES; i++)
            res_next[i] = (res_e[i] == SW'(i)) ? '0 : res_e[i] + SW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      filter_kind <= FILT_NONE;
      awaiting    <= 1'b1;
      first_row   <= 1'b1;
      halted      <= 1'b1;
      pend_clr    <= 1'b0;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) res[i] <= '0;
    end else if (accept) begin
      column      <= column_next;
      filter_kind <= filter_next;
      awaiting    <= awaiting_next;
      first_row   <= first_next;
      halted      <= halted_next;
      pend_clr    <= pend_next;
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) res[i] <= res_next[i];
    end
  end

endmodule

[hdl/psu_queue.sv]
// Small register queue between the front and back ends.
module psu_queue import psu_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = QUEUE_DEPTH,
  localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int NW   = $clog2(DEPTH + 1)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] head
);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wp, rp;
  logic [NW-1:0] count;

  assign full  = count == NW'(DEPTH);
  assign valid = count != '0;
  assign head  = entries[rp];

  always_ff @(posedge clk) begin
    if (push) entries[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push) wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      if (pop)  rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      if (push && !pop) count <= count + NW'(1);
      else if (pop && !push) count <= count - NW'(1);
    end
  end

endmodule

[hdl/psu_back.sv]
// Back end: line store, neighbor history, filter reversal and output register.
module psu_back import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int CW = $clog2(MAX_ROW_BYTES),
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  input  ctl_t          q_ctl,
  input  logic [CW-1:0] q_col,
  input  logic [SW-1:0] q_slot,
  input  logic [7:0]    q_byte,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          row_end,
  output logic          status
);

  logic [7:0] prior_row [MAX_ROW_BYTES];
  logic [7:0] mem_q;
  logic [7:0] left_h [MAX_PIXEL_BYTES];
  logic [7:0] ul_h [MAX_PIXEL_BYTES];

  logic          s_valid;
  ctl_t          s_ctl;
  logic [CW-1:0] s_col;
  logic [SW-1:0] s_slot;
  logic [7:0]    s_byte;
  logic          fwd;
  logic [7:0]    fwd_val;

  logic fire, wr;
  logic [7:0] a, b, c, v;

  assign fire  = s_valid && (!out_valid || out_ready);
  assign q_pop = q_valid && (!s_valid || fire);
  assign wr    = fire && !s_ctl.err;

  always_comb begin
    a = s_ctl.use_a ? left_h[s_slot] : 8'd0;
    b = s_ctl.first ? 8'd0 : (fwd ? fwd_val : mem_q);
    c = (!s_ctl.first && s_ctl.use_a) ? ul_h[s_slot] : 8'd0;
    unique case (s_ctl.filt)
      FILT_NONE:  v = s_byte;
      FILT_SUB:   v = s_byte + a;
      FILT_UP:    v = s_byte + b;
      FILT_AVG:   v = s_byte + 8'((9'(a) + 9'(b)) >> 1);
      FILT_PAETH: v = s_byte + paeth(a, b, c);
      default:    v = s_byte;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s_valid <= 1'b0;
    else if (q_pop) s_valid <= 1'b1;
    else if (fire) s_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s_ctl   <= q_ctl;
      s_col   <= q_col;
      s_slot  <= q_slot;
      s_byte  <= q_byte;
      fwd     <= wr && (s_col == q_col);
      fwd_val <= v;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) mem_q <= prior_row[q_col];
    if (wr) prior_row[s_col] <= v;
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      for (int i = 0; i < MAX_PIXEL_BYTES; i++) begin
        if (SW'(i) == s_slot) begin
          left_h[i] <= v;
          ul_h[i]   <= b;
        end else if (s_ctl.clr) begin
          left_h[i] <= 8'd0;
          ul_h[i]   <= 8'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (fire) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_byte <= s_ctl.err ? 8'd0 : v;
      row_end  <= s_ctl.err ? 1'b0 : s_ctl.row_end;
      status   <= s_ctl.err;
    end
  end

endmodule

[hdl/png_scanline_unfilter_top.sv]
// Top level of the PNG scanline unfilter: front end, queue and back end.
//
// Input channel (in_valid/in_ready) takes one byte of inflated image data per
// transfer; image_start marks the filter byte of row zero. Valid filter bytes make no
// result. Each filtered byte yields one result on the output channel
// (out_valid/out_ready): out_byte, row_end on the last byte of a scanline, and
// status set on the single error result for an unknown filter type, after which
// bytes are dropped until the next image start.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) writes row_bytes at
// index 0 and pixel_bytes at index 1; write only while the block is idle.
// Throughput is one byte per cycle while out_ready stays high, set by the neighbor
// history loop in the back end. out_valid follows the input transfer through the
// queue slot, the stage register with its line store read, and the output
// register; the result transfers at the first following edge with out_ready high.
// Reset clears the valid flags and the front end's scanline state and sets row_bytes and
// pixel_bytes to 1; the block drops bytes until an image start. When the receiver stalls,
// the output register holds, the back end stops and the queue fills; in_ready drops once the queue is full.
module png_scanline_unfilter_top import psu_pkg::*; #(
  parameter int MAX_ROW_BYTES   = MAX_ROW_BYTES_DEF,
  parameter int MAX_PIXEL_BYTES = MAX_PIXEL_BYTES_DEF,
  localparam int CW = $clog2(MAX_ROW_BYTES),
  localparam int SW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1,
  localparam int QW = $bits(ctl_t) + CW + SW + 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [ROW_BYTES_W-1:0] cfg_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_byte,
  input  logic                   image_start,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_byte,
  output logic                   row_end,
  output logic                   status
);

  logic          push, q_full, q_valid, q_pop;
  ctl_t          e_ctl, h_ctl;
  logic [CW-1:0] e_col, h_col;
  logic [SW-1:0] e_slot, h_slot;
  logic [7:0]    e_byte, h_byte;
  logic [QW-1:0] q_in, q_head;

  assign q_in = {e_ctl, e_col, e_slot, e_byte};
  assign {h_ctl, h_col, h_slot, h_byte} = q_head;

  psu_front #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_byte, .image_start,
    .q_full, .push, .e_ctl, .e_col, .e_slot, .e_byte
  );

  psu_queue #(
    .W    (QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk, .rst, .push, .push_data(q_in), .full(q_full),
    .pop(q_pop), .valid(q_valid), .head(q_head)
  );

  psu_back #(
    .MAX_ROW_BYTES  (MAX_ROW_BYTES),
    .MAX_PIXEL_BYTES(MAX_PIXEL_BYTES)
  ) u_back (
    .clk, .rst, .q_valid, .q_ctl(h_ctl), .q_col(h_col), .q_slot(h_slot),
    .q_byte(h_byte), .q_pop, .out_valid, .out_ready, .out_byte, .row_end, .status
  );

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> out_byte == 8'd0 && !row_end)
    else $error("error result carries data");

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(in_ready) |-> $past(in_valid))
    else $error("queue filled without an input transfer");

endmodule
